>>> rtl/ctpm_pkg.sv
package ctpm_pkg;

	localparam int TIME_WIDTH = 64;

	localparam logic [31:0] CYCLE_RESET = 32'd1000000;

	localparam logic [1:0] REG_CYCLE  = 2'd0;
	localparam logic [1:0] REG_TARGET = 2'd1;
	localparam logic [1:0] REG_SHIFT  = 2'd2;
	localparam logic [1:0] REG_DELAY  = 2'd3;

	localparam logic OP_RECORD = 1'b0;
	localparam logic OP_MISSED = 1'b1;

	typedef struct packed {
		logic        operation;
		logic [31:0] exchange_number;
		logic        wkc_matched;
		logic        host_times_valid;
		logic [63:0] scheduled_send;
		logic [63:0] send_start;
		logic [63:0] send_end;
		logic [63:0] receive_end;
		logic        clock_time_valid;
		logic signed [63:0] clock_time;
	} in_item_t;

	typedef struct packed {
		logic        accepted;
		logic        last_clock_sample_valid;
		logic        sample_safe;
		logic [63:0] tx_duration;
		logic [63:0] trip_time;
		logic signed [63:0] tx_lateness;
		logic [31:0] arr_phase;
		logic signed [31:0] phase_err;
		logic signed [31:0] sync_margin;
		logic [63:0] sample_total;
		logic [63:0] late_total;
		logic [63:0] missed_total;
	} out_item_t;

	function automatic logic [63:0] time_mask();
		return {64{1'b1}} >> (64 - TIME_WIDTH);
	endfunction

endpackage

>>> rtl/cyclic_timing_phase_monitor.sv
// Channel | Dir | Handshake             | Payload
// in      | in  | in_valid / in_stall   | in_item_t
// out     | out | out_valid / out_stall | out_item_t
// cfg     | in  | cfg_we                | cfg_index, cfg_data
// An observation with a clock sample goes through one host tracking step, a 64-step
// restoring remainder of the arrival time by the cycle length, a 32-step remainder of
// the Sync0 shift on the same unit, then centering, range tracking and the result
// register. Without a usable clock sample only host tracking comes before the result
// register; a missed deadline, a rejected setup or bad host ordering goes straight to
// it. in_stall is high while an item is in flight; the next item is taken in the
// cycle after the result registers. A result not yet taken holds only the last
// sequencer step. Reset clears all statistics and loads the register defaults.
module cyclic_timing_phase_monitor import ctpm_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  in_item_t    in_item,
	output logic        out_valid,
	input  logic        out_stall,
	output out_item_t   out_item,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_HOST  = 3'd1;
	localparam logic [2:0] ST_DIV   = 3'd2;
	localparam logic [2:0] ST_SYNC  = 3'd3;
	localparam logic [2:0] ST_CENT  = 3'd4;
	localparam logic [2:0] ST_TRACK = 3'd5;
	localparam logic [2:0] ST_DONE  = 3'd6;

	logic [2:0]  state_q;
	logic [31:0] cycle_q, target_q, shift_q, delay_q;
	in_item_t    item_q;

	logic [63:0] sample_q, wkc_q, host_cnt_q, clk_cnt_q, late_q, missed_q;
	logic [31:0] first_exch_q, last_exch_q;
	logic [63:0] host_t_q [4];
	logic [63:0] last_clk_q;
	logic [31:0] last_pe_q, last_mg_q;
	logic        clk_valid_q;
	logic [5:0]  present_q;
	logic [63:0] min_q [6];
	logic [63:0] max_q [6];

	logic        acc_q;
	logic        ovf_q;
	logic [63:0] dur_q, rtt_q, lat_q;
	logic [31:0] ap_q, pe_q, mg_q;

	// shared remainder unit
	logic [63:0] dividend_q;
	logic [31:0] rem_q;
	logic [6:0]  cnt_q;
	logic        neg_q;
	logic [31:0] sp_q;

	out_item_t   res_q;
	logic        res_valid_q;
	logic        res_load;

	logic [63:0] sch, st, en, rc, dlate, ulate, late_v;
	logic signed [63:0] t_ext, pd64;
	logic signed [64:0] arr65;
	logic        ovf;
	logic [32:0] rem_sh, rem_sub;
	logic        rem_ge;

	assign sch = in_item.scheduled_send & time_mask();
	assign st  = in_item.send_start & time_mask();
	assign en  = in_item.send_end & time_mask();
	assign rc  = in_item.receive_end & time_mask();
	assign dlate = st - sch;
	assign ulate = sch - st;
	always_comb begin
		if (st >= sch) begin
			late_v = dlate[63] ? 64'h7FFF_FFFF_FFFF_FFFF : dlate;
		end else begin
			late_v = ulate[63] ? {1'b1, 63'd0} : (64'd0 - ulate);
		end
	end

	logic [63:0] tm;
	assign tm    = in_item.clock_time & time_mask();
	assign t_ext = $signed((tm ^ (64'd1 << (TIME_WIDTH - 1))) - (64'd1 << (TIME_WIDTH - 1)));
	assign pd64  = {{32{delay_q[31]}}, delay_q};
	assign arr65 = {t_ext[63], t_ext} + {pd64[63], pd64};
	assign ovf   = arr65[64] != arr65[63];

	assign rem_sh  = {rem_q, dividend_q[63]};
	assign rem_ge  = rem_sh >= {1'b0, cycle_q};
	assign rem_sub = rem_ge ? rem_sh - {1'b0, cycle_q} : rem_sh;

	// centering, from registered values
	logic signed [33:0] d_mg, d_pe, half, c_mg, c_pe, m34;
	assign m34  = {2'b00, cycle_q};
	assign half = {3'b000, cycle_q[31:1]};
	assign d_mg = {2'b00, sp_q} - {2'b00, ap_q};
	assign d_pe = {2'b00, ap_q} - {2'b00, target_q};
	always_comb begin
		c_mg = d_mg;
		if (d_mg > half) c_mg = d_mg - m34;
		else if (d_mg < -half) c_mg = d_mg + m34;
		c_pe = d_pe;
		if (d_pe > half) c_pe = d_pe - m34;
		else if (d_pe < -half) c_pe = d_pe + m34;
	end

	function automatic logic sless(input logic [63:0] a, input logic [63:0] b);
		return $signed(a) < $signed(b);
	endfunction

	assign in_stall = (state_q != ST_IDLE);
	assign res_load = (state_q == ST_DONE) && (!res_valid_q || !out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cycle_q <= CYCLE_RESET;
			target_q <= '0; shift_q <= '0; delay_q <= '0;
			sample_q <= '0; wkc_q <= '0; host_cnt_q <= '0; clk_cnt_q <= '0;
			late_q <= '0; missed_q <= '0; first_exch_q <= '0; last_exch_q <= '0;
			for (int i = 0; i < 4; i++) host_t_q[i] <= '0;
			for (int i = 0; i < 6; i++) begin
				min_q[i] <= '0;
				max_q[i] <= '0;
			end
			last_clk_q <= '0; last_pe_q <= '0; last_mg_q <= '0;
			clk_valid_q <= 1'b0; present_q <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_CYCLE:  cycle_q  <= cfg_data;
					REG_TARGET: target_q <= cfg_data;
					REG_SHIFT:  shift_q  <= cfg_data;
					REG_DELAY:  delay_q  <= cfg_data;
					default: ;
				endcase
			end
			if (res_load) res_valid_q <= 1'b1;
			else if (!out_stall) res_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (in_valid && !in_stall) begin
						item_q <= in_item;
						ap_q <= '0; pe_q <= '0; mg_q <= '0;
						if (in_item.operation == OP_MISSED) begin
							if (missed_q != '1) missed_q <= missed_q + 64'd1;
							acc_q <= 1'b1;
							dur_q <= '0; rtt_q <= '0; lat_q <= '0;
							state_q <= ST_DONE;
						end else if (cycle_q != 0 && target_q < cycle_q &&
						    in_item.exchange_number != 0) begin
							if (sample_q == 0) first_exch_q <= in_item.exchange_number;
							last_exch_q <= in_item.exchange_number;
							sample_q <= sample_q + 64'd1;
							if (!in_item.wkc_matched && wkc_q != '1) wkc_q <= wkc_q + 64'd1;
							acc_q <= 1'b0;
							if (in_item.host_times_valid && (en < st || rc < st)) begin
								dur_q <= '0; rtt_q <= '0; lat_q <= '0;
								state_q <= ST_DONE;
							end else begin
								if (in_item.host_times_valid) begin
									dur_q <= en - st;
									rtt_q <= rc - st;
									lat_q <= late_v;
									host_cnt_q <= host_cnt_q + 64'd1;
									host_t_q[0] <= sch; host_t_q[1] <= st;
									host_t_q[2] <= en;  host_t_q[3] <= rc;
								end else begin
									dur_q <= '0; rtt_q <= '0; lat_q <= '0;
								end
								if (in_item.clock_time_valid && !ovf) begin
									last_clk_q <= t_ext;
									neg_q <= arr65[64];
									dividend_q <= arr65[64] ? 64'd0 - arr65[63:0] : arr65[63:0];
								end
								ovf_q <= ovf;
								state_q <= ST_HOST;
							end
						end else begin
							acc_q <= 1'b0;
							dur_q <= '0; rtt_q <= '0; lat_q <= '0;
							state_q <= ST_DONE;
						end
					end
				end
				ST_HOST: begin
					if (item_q.host_times_valid) begin
						for (int k = 0; k < 3; k++) begin
							logic [63:0] v;
							logic sg;
							v  = (k == 0) ? dur_q : (k == 1) ? rtt_q : lat_q;
							sg = (k == 2);
							if (!present_q[k]) begin
								min_q[k] <= v; max_q[k] <= v;
							end else begin
								if (sg ? sless(v, min_q[k]) : v < min_q[k]) min_q[k] <= v;
								if (sg ? sless(max_q[k], v) : v > max_q[k]) max_q[k] <= v;
							end
						end
						present_q[2:0] <= 3'b111;
					end
					if (!item_q.clock_time_valid) begin
						clk_valid_q <= 1'b0;
						acc_q <= 1'b1;
						state_q <= ST_DONE;
					end else if (ovf_q) begin
						state_q <= ST_DONE;
					end else begin
						clk_cnt_q <= clk_cnt_q + 64'd1;
						rem_q <= '0;
						cnt_q <= '0;
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (cnt_q == 7'd63) begin
						if (neg_q && rem_sub != 0)
							ap_q <= cycle_q - rem_sub[31:0];
						else
							ap_q <= rem_sub[31:0];
						// sync shift remainder: 32-bit magnitude, reuse the unit
						neg_q <= shift_q[31];
						dividend_q <= {(shift_q[31] ? 32'd0 - shift_q : shift_q), 32'd0};
						rem_q <= '0;
						cnt_q <= '0;
						state_q <= ST_SYNC;
					end else begin
						rem_q <= rem_sub[31:0];
						dividend_q <= {dividend_q[62:0], 1'b0};
						cnt_q <= cnt_q + 7'd1;
					end
				end
				ST_SYNC: begin
					rem_q <= rem_sub[31:0];
					dividend_q <= {dividend_q[62:0], 1'b0};
					cnt_q <= cnt_q + 7'd1;
					if (cnt_q == 7'd31) begin
						sp_q <= (neg_q && rem_sub != 0) ? cycle_q - rem_sub[31:0]
						    : rem_sub[31:0];
						state_q <= ST_CENT;
					end
				end
				ST_CENT: begin
					pe_q <= c_pe[31:0];
					mg_q <= c_mg[31:0];
					state_q <= ST_TRACK;
				end
				ST_TRACK: begin
					for (int k = 3; k < 6; k++) begin
						logic [63:0] v;
						v = (k == 3) ? {32'd0, ap_q} :
						    (k == 4) ? {{32{pe_q[31]}}, pe_q} : {{32{mg_q[31]}}, mg_q};
						if (!present_q[k]) begin
							min_q[k] <= v; max_q[k] <= v;
						end else begin
							if (sless(v, min_q[k])) min_q[k] <= v;
							if (sless(max_q[k], v)) max_q[k] <= v;
						end
					end
					present_q[5:3] <= 3'b111;
					last_pe_q <= pe_q;
					last_mg_q <= mg_q;
					clk_valid_q <= 1'b1;
					if (mg_q[31] && late_q != '1) late_q <= late_q + 64'd1;
					acc_q <= 1'b1;
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (res_load) begin
						res_q.accepted <= acc_q;
						res_q.last_clock_sample_valid <= clk_valid_q;
						res_q.sample_safe <= clk_valid_q && !last_mg_q[31];
						res_q.tx_duration <= dur_q;
						res_q.trip_time <= rtt_q;
						res_q.tx_lateness <= lat_q;
						res_q.arr_phase <= acc_q ? ap_q : '0;
						res_q.phase_err <= acc_q ? pe_q : '0;
						res_q.sync_margin <= acc_q ? mg_q : '0;
						res_q.sample_total <= sample_q;
						res_q.late_total <= late_q;
						res_q.missed_total <= missed_q;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid = res_valid_q;
	assign out_item  = res_q;

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE) |=> res_valid_q)
		else $error("result not registered");
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> in_stall)
		else $error("input taken while busy");
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> (cnt_q <= 7'd63))
		else $error("remainder count overrun");
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_TRACK) |-> (ap_q < cycle_q))
		else $error("phase out of range");

endmodule

>>> tb/sv/tb_cyclic_timing_phase_monitor.sv
`timescale 1ns / 1ps

module tb_cyclic_timing_phase_monitor;
	import ctpm_pkg::*;

	localparam int LIMIT_CYCLES = 2000000;
	localparam int N_RANDOM = 2000;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	in_item_t in_item;
	logic out_valid;
	logic out_stall;
	out_item_t out_item;
	logic cfg_we;
	logic [1:0] cfg_index;
	logic [31:0] cfg_data;

	cyclic_timing_phase_monitor dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
		.out_valid(out_valid), .out_stall(out_stall), .out_item(out_item),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// monitor model state
	logic [31:0] m_cycle, m_target, m_shift, m_delay;
	logic [63:0] m_samples, m_late, m_missed;
	logic m_clk_valid;
	logic signed [31:0] m_margin;

	out_item_t expected_results[$];
	int mismatch_count;
	int cycle_count;
	bit quiet_tail;
	bit out_quiet;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > LIMIT_CYCLES) begin
			$display("tb: failure");
			$finish;
		end
	end

	function automatic logic signed [63:0] centered_diff(logic signed [63:0] a,
		logic signed [63:0] b, logic [31:0] m);
		logic signed [63:0] d;
		logic signed [63:0] half;
		logic signed [63:0] mm;
		mm = $signed({32'd0, m});
		d = (a - b) % mm;
		half = mm / 2;
		if (d > half)
			d = d - mm;
		else if (d < -half)
			d = d + mm;
		return d;
	endfunction

	function automatic logic signed [63:0] pos_mod(logic signed [63:0] v, logic [31:0] m);
		logic signed [63:0] r;
		r = v % $signed({32'd0, m});
		if (r < 0)
			r = r + $signed({32'd0, m});
		return r;
	endfunction

	function automatic out_item_t monitor_step(in_item_t it);
		out_item_t r;
		bit ok;
		logic [63:0] d;
		logic signed [63:0] t, pd, ap, sp, mg, pe;
		r = '0;
		ok = 1'b1;
		if (it.operation == OP_MISSED) begin
			if (m_missed != '1)
				m_missed = m_missed + 1;
			r.accepted = 1'b1;
		end else if (m_cycle != 0 && m_target < m_cycle && it.exchange_number != 0) begin
			m_samples = m_samples + 1;
			if (it.host_times_valid) begin
				if (it.send_end < it.send_start || it.receive_end < it.send_start) begin
					ok = 1'b0;
				end else begin
					r.tx_duration = it.send_end - it.send_start;
					r.trip_time = it.receive_end - it.send_start;
					if (it.send_start >= it.scheduled_send) begin
						d = it.send_start - it.scheduled_send;
						r.tx_lateness = d[63] ? 64'h7fff_ffff_ffff_ffff : d;
					end else begin
						d = it.scheduled_send - it.send_start;
						r.tx_lateness = d[63] ? 64'h8000_0000_0000_0000 : -d;
					end
				end
			end
			if (ok && !it.clock_time_valid) begin
				m_clk_valid = 1'b0;
				r.accepted = 1'b1;
			end else if (ok) begin
				t = it.clock_time;
				pd = $signed(m_delay);
				t = t + pd;
				if ((pd > 0 && t < it.clock_time) || (pd < 0 && t > it.clock_time)) begin
					ok = 1'b0;
				end else begin
					ap = pos_mod(t, m_cycle);
					sp = pos_mod($signed(m_shift), m_cycle);
					mg = centered_diff(sp, ap, m_cycle);
					pe = centered_diff(ap, $signed({32'd0, m_target}), m_cycle);
					m_margin = mg[31:0];
					m_clk_valid = 1'b1;
					if (mg < 0 && m_late != '1)
						m_late = m_late + 1;
					r.arr_phase = ap[31:0];
					r.phase_err = pe[31:0];
					r.sync_margin = mg[31:0];
					r.accepted = 1'b1;
				end
			end
		end
		r.last_clock_sample_valid = m_clk_valid;
		r.sample_safe = m_clk_valid && m_margin >= 0;
		r.sample_total = m_samples;
		r.late_total = m_late;
		r.missed_total = m_missed;
		return r;
	endfunction

	task automatic check_result(out_item_t e, out_item_t a);
		if (e !== a) begin
			mismatch_count++;
			if (mismatch_count <= 10)
				$display("mismatch: expected %h actual %h", e, a);
		end
	endtask

	// collect results and apply receiver stalls
	initial begin
		int burst;
		out_stall = 1'b0;
		burst = 0;
		forever begin
			@(posedge clk);
			if (out_valid && !out_stall) begin
				if (expected_results.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("unexpected transaction %h", out_item);
				end else begin
					check_result(expected_results.pop_front(), out_item);
				end
			end
			@(negedge clk);
			if (quiet_tail || out_quiet) begin
				out_stall <= 1'b0;
			end else if (burst > 0) begin
				burst--;
				out_stall <= 1'b1;
			end else if ($urandom_range(0, 9) == 0) begin
				burst = $urandom_range(1, 14) - 1;
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	task automatic write_reg(logic [1:0] idx, logic [31:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_CYCLE: m_cycle = val;
			REG_TARGET: m_target = val;
			REG_SHIFT: m_shift = val;
			default: m_delay = val;
		endcase
	endtask

	task automatic drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (100) @(posedge clk);
	endtask

	task automatic send_item(in_item_t it, bit gaps);
		int g;
		@(negedge clk);
		if (gaps && $urandom_range(0, 7) == 0) begin
			g = $urandom_range(1, 14);
			in_valid <= 1'b0;
			repeat (g) @(negedge clk);
		end
		in_valid <= 1'b1;
		in_item <= it;
		do @(posedge clk); while (in_stall);
		expected_results.push_back(monitor_step(it));
	endtask

	function automatic logic [63:0] rand64();
		return {$urandom(), $urandom()};
	endfunction

	function automatic in_item_t random_item();
		in_item_t it;
		logic [63:0] base;
		it = '0;
		it.operation = ($urandom_range(0, 15) == 0) ? OP_MISSED : OP_RECORD;
		it.exchange_number = ($urandom_range(0, 19) == 0) ? 32'd0 : $urandom();
		it.wkc_matched = $urandom_range(0, 1);
		it.host_times_valid = $urandom_range(0, 3) != 0;
		it.clock_time_valid = $urandom_range(0, 3) != 0;
		case ($urandom_range(0, 3))
			0: base = rand64();
			1: base = {32'd0, $urandom()};
			2: base = 64'hffff_ffff_0000_0000 | $urandom();
			default: base = 64'h8000_0000_0000_0000 ^ $urandom();
		endcase
		it.scheduled_send = ($urandom_range(0, 7) == 0) ? rand64() :
			base + $urandom_range(0, 100000) - 50000;
		it.send_start = base;
		it.send_end = ($urandom_range(0, 9) == 0) ? base - $urandom_range(1, 9) :
			base + $urandom_range(0, 100000);
		it.receive_end = ($urandom_range(0, 9) == 0) ? base - $urandom_range(1, 9) :
			base + $urandom_range(0, 1000000);
		case ($urandom_range(0, 3))
			0: it.clock_time = rand64();
			1: it.clock_time = 64'h7fff_ffff_ffff_ffff - $urandom_range(0, 3);
			2: it.clock_time = 64'h8000_0000_0000_0000 + $urandom_range(0, 3);
			default: it.clock_time = {{32{1'b0}}, $urandom()} - 64'd2147483648;
		endcase
		return it;
	endfunction

	typedef struct {
		in_item_t item;
		bit fixed;
		out_item_t result;
	} stim_row_t;

	initial begin
		stim_row_t rows[$];
		in_item_t it;
		out_item_t exp_r;
		int n;
		logic [31:0] cfg_sets[5][4];

		arst_n = 1'b0;
		in_valid = 1'b0;
		in_item = '0;
		cfg_we = 1'b0;
		cfg_index = REG_CYCLE;
		cfg_data = '0;
		mismatch_count = 0;
		cycle_count = 0;
		quiet_tail = 1'b0;
		out_quiet = 1'b0;
		m_cycle = CYCLE_RESET;
		m_target = '0;
		m_shift = '0;
		m_delay = '0;
		m_samples = '0;
		m_late = '0;
		m_missed = '0;
		m_clk_valid = 1'b0;
		m_margin = '0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed table
		it = '0;
		it.operation = OP_MISSED;
		exp_r = '0;
		exp_r.accepted = 1'b1;
		exp_r.missed_total = 64'd1;
		rows.push_back('{it, 1'b1, exp_r});
		it = '0;
		exp_r = '0;
		exp_r.missed_total = 64'd1;
		rows.push_back('{it, 1'b1, exp_r});
		it = '0;
		it.exchange_number = 32'hffff_ffff;
		it.wkc_matched = 1'b1;
		exp_r = '0;
		exp_r.accepted = 1'b1;
		exp_r.sample_total = 64'd1;
		exp_r.missed_total = 64'd1;
		rows.push_back('{it, 1'b1, exp_r});
		it = '0;
		it.exchange_number = 32'd1;
		it.host_times_valid = 1'b1;
		it.send_start = 64'd10;
		it.send_end = 64'd5;
		it.receive_end = 64'd20;
		rows.push_back('{it, 1'b0, exp_r});
		it.send_end = 64'd20;
		it.receive_end = 64'd5;
		rows.push_back('{it, 1'b0, exp_r});
		it = '0;
		it.exchange_number = 32'd2;
		it.host_times_valid = 1'b1;
		it.scheduled_send = '1;
		it.send_start = '0;
		it.send_end = '1;
		it.receive_end = '1;
		it.clock_time_valid = 1'b1;
		it.clock_time = 64'h7fff_ffff_ffff_ffff;
		rows.push_back('{it, 1'b0, exp_r});
		it.scheduled_send = '0;
		it.send_start = 64'h8000_0000_0000_0000;
		it.clock_time = 64'h8000_0000_0000_0000;
		rows.push_back('{it, 1'b0, exp_r});
		it.send_start = '1;
		it.clock_time = -64'sd1;
		rows.push_back('{it, 1'b0, exp_r});
		it.clock_time = 64'sd499999;
		rows.push_back('{it, 1'b0, exp_r});
		it.clock_time = 64'sd500001;
		rows.push_back('{it, 1'b0, exp_r});
		for (int i = 0; i < rows.size(); i++) begin
			send_item(rows[i].item, 1'b0);
			if (rows[i].fixed) begin
				void'(expected_results.pop_back());
				expected_results.push_back(rows[i].result);
			end
		end
		drain();

		cfg_sets[0] = '{32'd1, 32'd0, 32'h8000_0000, 32'h7fff_ffff};
		cfg_sets[1] = '{32'hffff_ffff, 32'hffff_fffe, 32'h7fff_ffff, 32'h8000_0000};
		cfg_sets[2] = '{32'd1000, 32'd1000, 32'd250, 32'hffff_fc18};
		cfg_sets[3] = '{32'd0, 32'd5, 32'd0, 32'd0};
		cfg_sets[4] = '{32'd12345, 32'd6000, 32'hffff_f000, 32'd777};
		for (int s = 0; s < 5; s++) begin
			for (int r = 0; r < 4; r++)
				write_reg(r[1:0], cfg_sets[s][r]);
			for (int i = 0; i < 8; i++)
				send_item(random_item(), 1'b1);
			drain();
		end

		// random phase
		n = 0;
		while (n < N_RANDOM) begin
			if (n % 400 == 0) begin
				drain();
				write_reg(REG_CYCLE, ($urandom_range(0, 3) == 0) ? $urandom() :
					$urandom_range(1, 2000000));
				write_reg(REG_TARGET, ($urandom_range(0, 9) == 0) ? $urandom() :
					$urandom_range(0, m_cycle - 1));
				write_reg(REG_SHIFT, $urandom());
				write_reg(REG_DELAY, ($urandom_range(0, 1) == 0) ? $urandom() :
					$urandom_range(0, 20000) - 10000);
			end
			if (n > N_RANDOM - 200) begin
				quiet_tail = 1'b1;
			end
			if (n == N_RANDOM / 2) begin
				out_quiet = 1'b1;
				drain();
				out_quiet = 1'b0;
			end
			send_item(random_item(), !quiet_tail);
			n++;
		end

		@(negedge clk);
		in_valid <= 1'b0;
		fork
			begin
				while (expected_results.size() != 0)
					@(posedge clk);
				repeat (100) @(posedge clk);
			end
			begin
				repeat (200000) @(posedge clk);
				mismatch_count++;
			end
		join_any
		disable fork;
		if (mismatch_count == 0 && expected_results.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
